// ----- src/bcc_pkg.sv -----
// Shared types, constants, control store and helpers of the balance cascade controller.
package bcc_pkg;

   localparam int StepW   = 4;
   localparam int MulW    = 33;
   localparam int ProdW   = 2 * MulW;
   localparam int AccW    = 36;
   localparam int FiltShift = 10;
   localparam int QuotShift = 36;

   typedef logic [StepW-1:0] step_type;

   localparam step_type StepDead = StepW'(11);

   // 0.3 * 256 in Q.10, 0.7 in Q.10, ceil(2^36 / 25)
   localparam logic signed [MulW-1:0] FiltNew  = 33'sd78592;
   localparam logic signed [MulW-1:0] FiltOld  = 33'sd717;
   localparam logic signed [MulW-1:0] Recip25  = 33'sd2748779070;
   localparam logic signed [AccW-1:0] RoundHalf = 36'sd512;

   typedef enum logic [2:0] {
      A_SPEED, A_FILT, A_PITCH, A_PRATE, A_YRATE, A_INTEG, A_QUO
   } mul_a_type;

   typedef enum logic [2:0] {
      B_FNEW, B_FOLD, B_ANGLE, B_RATE, B_SGAIN, B_YAW, B_RECIP
   } mul_b_type;

   typedef enum logic [1:0] {
      ACC_HOLD, ACC_LOAD_RND, ACC_LOAD, ACC_ADD
   } acc_op_type;

   typedef enum logic [2:0] {
      TERM_RAW, TERM_SH12, TERM_SH20, TERM_SH28, TERM_QUOT
   } term_type;

   typedef enum logic [2:0] {
      CSR_DEAD_BAND, CSR_ANGLE_GAIN, CSR_RATE_GAIN, CSR_SPEED_GAIN,
      CSR_YAW_GAIN, CSR_INTEGRAL_HIGH, CSR_INTEGRAL_LOW
   } csr_index_type;

   typedef struct packed {
      mul_a_type  mul_a;
      mul_b_type  mul_b;
      acc_op_type acc_op;
      term_type   term;
      logic       wr_filt;
      logic       wr_integ;
      logic       wr_quo;
      logic       wr_yaw;
      logic       wr_sum;
      logic       wr_out;
      logic       clr_state;
      logic       jmp_band;
      logic       last;
   } ctrl_word_type;

   typedef struct packed {
      logic in_band;
      logic out_full;
   } status_type;

   typedef struct packed {
      logic        [22:0] dead_band;
      logic signed [23:0] angle_gain;
      logic signed [23:0] rate_gain;
      logic signed [23:0] speed_gain;
      logic signed [23:0] yaw_gain;
      logic signed [31:0] integral_high;
      logic signed [31:0] integral_low;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      dead_band:     23'd721,
      angle_gain:    24'sd1013760,
      rate_gain:     24'sd73933,
      speed_gain:    -24'sd71680,
      yaw_gain:      -24'sd3277,
      integral_high: 32'sd1000000,
      integral_low:  -32'sd1000000
   };

   localparam ctrl_word_type CtrlNop = '{
      mul_a: A_SPEED, mul_b: B_FNEW, acc_op: ACC_HOLD, term: TERM_RAW,
      wr_filt: 1'b0, wr_integ: 1'b0, wr_quo: 1'b0, wr_yaw: 1'b0,
      wr_sum: 1'b0, wr_out: 1'b0, clr_state: 1'b0, jmp_band: 1'b0, last: 1'b0
   };

   // Microprogram. The multiplier result of step n is seen in step n+1.
   function automatic ctrl_word_type ctrl_rom(input step_type step);
      ctrl_word_type w;
      w = CtrlNop;
      unique case (step)
         StepW'(0): begin   // speed * 0.3, preload rounding, leave on dead band
            w.mul_a = A_SPEED; w.mul_b = B_FNEW;
            w.acc_op = ACC_LOAD_RND; w.jmp_band = 1'b1;
         end
         StepW'(1): begin
            w.mul_a = A_FILT; w.mul_b = B_FOLD;
            w.acc_op = ACC_ADD; w.term = TERM_RAW;
         end
         StepW'(2): begin   // filter done
            w.mul_a = A_PITCH; w.mul_b = B_ANGLE;
            w.acc_op = ACC_ADD; w.term = TERM_RAW; w.wr_filt = 1'b1;
         end
         StepW'(3): begin   // integral update, start angle sum
            w.mul_a = A_PRATE; w.mul_b = B_RATE;
            w.acc_op = ACC_LOAD; w.term = TERM_SH28; w.wr_integ = 1'b1;
         end
         StepW'(4): begin
            w.mul_a = A_FILT; w.mul_b = B_SGAIN;
            w.acc_op = ACC_ADD; w.term = TERM_SH12;
         end
         StepW'(5): begin
            w.mul_a = A_INTEG; w.mul_b = B_SGAIN;
            w.acc_op = ACC_ADD; w.term = TERM_SH20;
         end
         StepW'(6): begin   // magnitude of integral product for the /200
            w.mul_a = A_YRATE; w.mul_b = B_YAW; w.wr_quo = 1'b1;
         end
         StepW'(7): begin
            w.mul_a = A_QUO; w.mul_b = B_RECIP;
            w.term = TERM_SH12; w.wr_yaw = 1'b1;
         end
         StepW'(8): begin
            w.acc_op = ACC_ADD; w.term = TERM_QUOT;
         end
         StepW'(9): begin
            w.wr_sum = 1'b1;
         end
         StepW'(10): begin
            w.wr_out = 1'b1; w.last = 1'b1;
         end
         StepDead: begin
            w.clr_state = 1'b1; w.wr_out = 1'b1; w.last = 1'b1;
         end
         default: w = CtrlNop;
      endcase
      return w;
   endfunction

   // Signed shift right that rounds toward zero.
   function automatic logic signed [ProdW-1:0] trunc_shr(
      input logic signed [ProdW-1:0] p,
      input int unsigned             sh
   );
      logic signed [ProdW-1:0] bias;
      bias = p[ProdW-1] ? ((ProdW'(1) <<< sh) - ProdW'(1)) : '0;
      return (p + bias) >>> sh;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
      logic signed [AccW-1:0] hi;
      logic signed [AccW-1:0] lo;
      hi = $signed(AccW'(32'h7FFF_FFFF));
      lo = $signed({{(AccW-31){1'b1}}, 31'b0});
      if (v > hi) begin
         return hi[31:0];
      end else if (v < lo) begin
         return lo[31:0];
      end
      return v[31:0];
   endfunction

endpackage

// ----- src/bcc_sequencer.sv -----
// Microcode sequencer: step counter, control store lookup and jumps.
module bcc_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  bcc_pkg::status_type    status,
   output bcc_pkg::ctrl_word_type ctrl,
   output logic                   busy
);

   logic              busy_ff, busy_in;
   bcc_pkg::step_type step_ff, step_in;

   assign ctrl = busy_ff ? bcc_pkg::ctrl_rom(step_ff) : bcc_pkg::CtrlNop;
   assign busy = busy_ff;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      priority if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            step_in = '0;
         end
      end else if (ctrl.last) begin
         // wait here while the previous result is still unclaimed
         if (!status.out_full) begin
            busy_in = 1'b0;
            step_in = '0;
         end
      end else if (ctrl.jmp_band && status.in_band) begin
         step_in = bcc_pkg::StepDead;
      end else begin
         step_in = step_ff + bcc_pkg::StepW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

endmodule

// ----- src/bcc_datapath.sv -----
// Datapath: shared multiplier, accumulator, controller state and result register.
module bcc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [23:0]     req_pitch_angle,
   input  logic signed [15:0]     req_pitch_rate,
   input  logic signed [15:0]     req_yaw_rate,
   input  logic signed [15:0]     req_wheel_speed,
   input  bcc_pkg::cfg_type       cfg,
   input  bcc_pkg::ctrl_word_type ctrl,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic signed [31:0]     rsp_drive_left,
   output logic signed [31:0]     rsp_drive_right,
   output logic signed [31:0]     rsp_drive_sum,
   output logic                   rsp_tilt_direction,
   output bcc_pkg::status_type    status
);

   localparam int MulW  = bcc_pkg::MulW;
   localparam int ProdW = bcc_pkg::ProdW;
   localparam int AccW  = bcc_pkg::AccW;

   logic signed [23:0] pitch_ff;
   logic signed [15:0] prate_ff, yrate_ff, speed_ff;
   logic signed [23:0] filt_ff, filt_in;
   logic signed [31:0] integ_ff, integ_in;
   logic signed [ProdW-1:0] prod_ff, prod_in;
   logic signed [AccW-1:0]  acc_ff, acc_in;
   logic        [31:0]      quo_ff;
   logic                    neg_ff;
   logic signed [27:0]      yaw_ff;
   logic signed [31:0]      sum_ff;
   logic                    valid_ff;
   logic signed [31:0]      left_ff, right_ff, drsum_ff;
   logic                    tilt_ff;

   logic signed [MulW-1:0]  mul_a, mul_b;
   logic signed [AccW-1:0]  term, acc_sum;
   logic signed [ProdW-1:0] prod_mag;
   logic signed [32:0]      integ_sum, integ_hi, integ_lo, integ_c1, integ_c2;
   logic signed [24:0]      pitch_x, band_x;
   logic                    out_full, out_load;

   // dead band: -dead_band < pitch < dead_band
   assign pitch_x = $signed({pitch_ff[23], pitch_ff});
   assign band_x  = $signed({2'b00, cfg.dead_band});

   assign out_full = valid_ff && !rsp_ready;
   assign out_load = ctrl.wr_out && !out_full;

   assign status.in_band  = (pitch_x < band_x) && (pitch_x > -band_x);
   assign status.out_full = out_full;

   always_comb begin
      unique case (ctrl.mul_a)
         bcc_pkg::A_SPEED: mul_a = MulW'(speed_ff);
         bcc_pkg::A_FILT:  mul_a = MulW'(filt_ff);
         bcc_pkg::A_PITCH: mul_a = MulW'(pitch_ff);
         bcc_pkg::A_PRATE: mul_a = MulW'(prate_ff);
         bcc_pkg::A_YRATE: mul_a = MulW'(yrate_ff);
         bcc_pkg::A_INTEG: mul_a = MulW'(integ_ff);
         bcc_pkg::A_QUO:   mul_a = $signed({1'b0, quo_ff});
         default:          mul_a = '0;
      endcase
      unique case (ctrl.mul_b)
         bcc_pkg::B_FNEW:  mul_b = bcc_pkg::FiltNew;
         bcc_pkg::B_FOLD:  mul_b = bcc_pkg::FiltOld;
         bcc_pkg::B_ANGLE: mul_b = MulW'(cfg.angle_gain);
         bcc_pkg::B_RATE:  mul_b = MulW'(cfg.rate_gain);
         bcc_pkg::B_SGAIN: mul_b = MulW'(cfg.speed_gain);
         bcc_pkg::B_YAW:   mul_b = MulW'(cfg.yaw_gain);
         bcc_pkg::B_RECIP: mul_b = bcc_pkg::Recip25;
         default:          mul_b = '0;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // scaled view of the last product
   always_comb begin
      unique case (ctrl.term)
         bcc_pkg::TERM_RAW:  term = AccW'(prod_ff);
         bcc_pkg::TERM_SH12: term = AccW'(bcc_pkg::trunc_shr(prod_ff, 12));
         bcc_pkg::TERM_SH20: term = AccW'(bcc_pkg::trunc_shr(prod_ff, 20));
         bcc_pkg::TERM_SH28: term = AccW'(bcc_pkg::trunc_shr(prod_ff, 28));
         bcc_pkg::TERM_QUOT: begin
            // floor(n * ceil(2^36/25) / 2^36) == floor(n / 25), sign restored
            term = neg_ff ? -$signed(AccW'(prod_ff[ProdW-1:bcc_pkg::QuotShift]))
                          :  $signed(AccW'(prod_ff[ProdW-1:bcc_pkg::QuotShift]));
         end
         default:            term = '0;
      endcase
   end

   assign acc_sum = acc_ff + term;

   always_comb begin
      unique case (ctrl.acc_op)
         bcc_pkg::ACC_HOLD:     acc_in = acc_ff;
         bcc_pkg::ACC_LOAD_RND: acc_in = bcc_pkg::RoundHalf;
         bcc_pkg::ACC_LOAD:     acc_in = term;
         bcc_pkg::ACC_ADD:      acc_in = acc_sum;
         default:               acc_in = acc_ff;
      endcase
   end

   // rounded filter result: floor((a + 512) / 1024)
   assign filt_in = acc_sum[bcc_pkg::FiltShift+23:bcc_pkg::FiltShift];

   // integral with upper clamp first, lower clamp last
   assign integ_sum = $signed({integ_ff[31], integ_ff}) + 33'(filt_ff);
   assign integ_hi  = 33'(cfg.integral_high);
   assign integ_lo  = 33'(cfg.integral_low);
   assign integ_c1  = (integ_sum > integ_hi) ? integ_hi : integ_sum;
   assign integ_c2  = (integ_c1 <= integ_lo) ? integ_lo : integ_c1;
   assign integ_in  = integ_c2[31:0];

   // |integral * gain| / 2^23; the remaining /25 goes through the multiplier
   assign prod_mag = prod_ff[ProdW-1] ? -prod_ff : prod_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         pitch_ff <= req_pitch_angle;
         prate_ff <= req_pitch_rate;
         yrate_ff <= req_yaw_rate;
         speed_ff <= req_wheel_speed;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (ctrl.wr_quo) begin
         quo_ff <= prod_mag[54:23];
         neg_ff <= prod_ff[ProdW-1];
      end
      if (ctrl.wr_yaw) begin
         yaw_ff <= term[27:0];
      end
      if (ctrl.wr_sum) begin
         sum_ff <= bcc_pkg::sat32(acc_ff);
      end
      if (out_load) begin
         tilt_ff <= pitch_ff[23];
         if (ctrl.clr_state) begin
            left_ff  <= '0;
            right_ff <= '0;
            drsum_ff <= '0;
         end else begin
            left_ff  <= bcc_pkg::sat32($signed(AccW'(sum_ff)) - $signed(AccW'(yaw_ff)));
            right_ff <= bcc_pkg::sat32($signed(AccW'(sum_ff)) + $signed(AccW'(yaw_ff)));
            drsum_ff <= sum_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff  <= '0;
         integ_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (ctrl.clr_state) begin
            filt_ff  <= '0;
            integ_ff <= '0;
         end else begin
            if (ctrl.wr_filt) begin
               filt_ff <= filt_in;
            end
            if (ctrl.wr_integ) begin
               integ_ff <= integ_in;
            end
         end
         if (out_load) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_drive_left     = left_ff;
   assign rsp_drive_right    = right_ff;
   assign rsp_drive_sum      = drsum_ff;
   assign rsp_tilt_direction = tilt_ff;

endmodule

// ----- src/balance_cascade_controller.sv -----
// Top level of the balance cascade controller: ports, register file, sequencer and datapath.
//
// Two-wheel balancing controller. Each req_ transaction is one control tick (pitch angle
// in Q7.16, raw pitch and yaw gyro rates, wheel speed) and yields exactly one rsp_
// transaction with the left, right and summed drive and the tilt direction. Outside the
// dead band the block runs an angle PD term plus a speed PI term (speed low-pass
// filtered 0.3/0.7, integral clamped to integral_low..integral_high, integral gain
// speed_gain/200) and splits the sum by the yaw term. Inside the dead band the filter
// and integral are cleared and all drives are zero. Gains are Q12.12; products are
// truncated toward zero and drives saturate to 32-bit signed. A new tick is accepted
// only once the previous tick's microprogram has ended; every step is one word of a
// microprogram driving a single shared 33x33 multiplier, and the dead band run is
// shorter. A finished result sits in the rsp_ output register, and the next tick is
// taken meanwhile; a tick only stalls in its last step while the previous result is
// still unclaimed. Registers are written on the csr_ transaction channel by index
// (0 dead_band .. 6 integral_low, higher indexes ignored) and must be written only
// while no tick is in flight; csr_ready is always high.
module balance_cascade_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_pitch_angle,
   input  logic signed [15:0] req_pitch_rate,
   input  logic signed [15:0] req_yaw_rate,
   input  logic signed [15:0] req_wheel_speed,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_drive_left,
   output logic signed [31:0] rsp_drive_right,
   output logic signed [31:0] rsp_drive_sum,
   output logic               rsp_tilt_direction,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [2:0]  csr_index,
   input  logic        [31:0] csr_data
);

   bcc_pkg::cfg_type       cfg_ff, cfg_in;
   bcc_pkg::ctrl_word_type ctrl;
   bcc_pkg::status_type    status;
   logic                   busy;
   logic                   start;

   // new tick only when the sequencer is free
   assign req_ready = !busy;
   assign start     = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // register file write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bcc_pkg::CSR_DEAD_BAND:     cfg_in.dead_band     = csr_data[22:0];
            bcc_pkg::CSR_ANGLE_GAIN:    cfg_in.angle_gain    = csr_data[23:0];
            bcc_pkg::CSR_RATE_GAIN:     cfg_in.rate_gain     = csr_data[23:0];
            bcc_pkg::CSR_SPEED_GAIN:    cfg_in.speed_gain    = csr_data[23:0];
            bcc_pkg::CSR_YAW_GAIN:      cfg_in.yaw_gain      = csr_data[23:0];
            bcc_pkg::CSR_INTEGRAL_HIGH: cfg_in.integral_high = csr_data;
            bcc_pkg::CSR_INTEGRAL_LOW:  cfg_in.integral_low  = csr_data;
            default:                    cfg_in = cfg_ff;   // index past the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= bcc_pkg::CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bcc_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   bcc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .req_pitch_angle    (req_pitch_angle),
      .req_pitch_rate     (req_pitch_rate),
      .req_yaw_rate       (req_yaw_rate),
      .req_wheel_speed    (req_wheel_speed),
      .cfg                (cfg_ff),
      .ctrl               (ctrl),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_drive_left     (rsp_drive_left),
      .rsp_drive_right    (rsp_drive_right),
      .rsp_drive_sum      (rsp_drive_sum),
      .rsp_tilt_direction (rsp_tilt_direction),
      .status             (status)
   );

   // an accepted tick always starts the microprogram
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> busy)
      else $error("accepted tick did not start the sequencer");

   // a result only appears at the end of a running microprogram
   a_result_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(busy))
      else $error("result raised without a tick in flight");

   // the output register is loaded only in a final step
   a_load_in_last: assert property (@(posedge clock) disable iff (reset)
      ctrl.wr_out |-> ctrl.last && busy)
      else $error("output write outside the final microprogram step");

endmodule
